FILE: rtl/frt_pkg.sv
// types and constants shared by the fragment reassembly tracker
// no dependencies
`timescale 1ns / 1ps

package frt_pkg;

  localparam int SLOT_FW     = 10;
  localparam int ID_FW       = 22;
  localparam int LEN_FW      = 16;
  localparam int RECIP_SHIFT = 2 * SLOT_FW;

  typedef enum logic [1:0] {
    CTRL_WHOLE   = 2'd0,
    CTRL_FIRST   = 2'd1,
    CTRL_CONT    = 2'd2,
    CTRL_UNKNOWN = 2'd3
  } ctrl_code_t;

  typedef enum logic [2:0] {
    ACT_WHOLE    = 3'd0,
    ACT_START    = 3'd1,
    ACT_APPEND   = 3'd2,
    ACT_COMPLETE = 3'd3,
    ACT_DROP     = 3'd4,
    ACT_FLUSH    = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ERR_NONE           = 4'd0,
    ERR_PART_BIG       = 4'd1,
    ERR_NAME_BIG       = 4'd2,
    ERR_WHOLE_MISMATCH = 4'd3,
    ERR_TOTAL_SMALL    = 4'd4,
    ERR_EXP_CONT       = 4'd5,
    ERR_TOTAL_MISMATCH = 4'd6,
    ERR_EXP_FIRST      = 4'd7,
    ERR_UNKNOWN        = 4'd8,
    ERR_OVERRUN        = 4'd9
  } err_t;

  typedef struct packed {
    ctrl_code_t          ctrl_code;
    logic [SLOT_FW-1:0]  sender_slot;
    logic [ID_FW-1:0]    src_id;
    logic [LEN_FW-1:0]   total_len;
    logic [LEN_FW-1:0]   name_part_len;
    logic [LEN_FW-1:0]   part_len;
  } hdr_t;

  typedef struct packed {
    action_t             action;
    err_t                error_code;
    logic [LEN_FW-1:0]   write_offset;
    logic [LEN_FW-1:0]   msg_name_len;
    logic [LEN_FW-1:0]   msg_data_len;
    logic                stale_cleared;
    logic [SLOT_FW-1:0]  out_slot;
    logic [ID_FW-1:0]    out_id;
  } res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic res_free;
  } dp_stat_t;

endpackage

FILE: rtl/frt_ctrl.sv
// sequencing state machine for the fragment reassembly tracker
// depends on frt_pkg
`timescale 1ns / 1ps

module frt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              hdr_valid,
  output logic              hdr_stall,
  input  frt_pkg::dp_stat_t stat,
  output frt_pkg::ctl_cmd_t cmd
);

  frt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      frt_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = frt_pkg::ST_IDLE;
      end
      frt_pkg::ST_IDLE: begin
        if (hdr_valid) state_next = frt_pkg::ST_LOOKUP;
      end
      frt_pkg::ST_LOOKUP: begin
        state_next = frt_pkg::ST_DECIDE;
      end
      frt_pkg::ST_DECIDE: begin
        if (stat.res_free) state_next = frt_pkg::ST_IDLE;
      end
      default: begin
        state_next = frt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    hdr_stall  = 1'b1;
    cmd        = '0;
    unique case (state)
      frt_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      frt_pkg::ST_IDLE: begin
        hdr_stall = 1'b0;
        cmd.load  = hdr_valid;
      end
      frt_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      frt_pkg::ST_DECIDE: begin
        cmd.commit = stat.res_free;
      end
      default: begin
        hdr_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/frt_datapath.sv
// header register, slot index reduction, context memories, decision logic
// and result register; depends on frt_pkg
`timescale 1ns / 1ps

module frt_datapath #(
  parameter int SLOT_COUNT    = 1024,
  parameter int MAX_PART_BODY = 4064,
  parameter int LEN_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  frt_pkg::ctl_cmd_t cmd,
  output frt_pkg::dp_stat_t stat,
  input  frt_pkg::hdr_t     hdr,
  output logic              res_valid,
  input  logic              res_stall,
  output frt_pkg::res_t     res
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RECIP  = (2 ** frt_pkg::RECIP_SHIFT + SLOT_COUNT - 1) / SLOT_COUNT;
  localparam int PROD_W = frt_pkg::SLOT_FW + frt_pkg::RECIP_SHIFT;
  localparam int QN_W   = 2 * frt_pkg::SLOT_FW + 1;

  // header and slot quotient
  frt_pkg::hdr_t                hdr_q;
  logic [frt_pkg::SLOT_FW-1:0]  quo;
  logic [PROD_W-1:0]            prod;

  assign prod = PROD_W'(hdr.sender_slot) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hdr_q <= hdr;
      quo   <= prod[PROD_W-1:frt_pkg::RECIP_SHIFT];
    end
  end

  // slot index is sender_slot modulo the context count
  logic [QN_W-1:0]   qn;
  logic [QN_W-1:0]   rem;
  logic [SLOT_W-1:0] idx_calc;
  logic [SLOT_W-1:0] idx;

  assign qn       = QN_W'(quo) * QN_W'(SLOT_COUNT);
  assign rem      = QN_W'(hdr_q.sender_slot) - qn;
  assign idx_calc = rem[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.lookup) idx <= idx_calc;
  end

  // valid-bit clearing sweep
  logic [SLOT_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clear_last = (clr_cnt == SLOT_W'(SLOT_COUNT - 1));

  // context memories
  logic                        vld_mem [SLOT_COUNT];
  logic [frt_pkg::ID_FW-1:0]   snd_mem [SLOT_COUNT];
  logic [LEN_BITS-1:0]         tot_mem [SLOT_COUNT];
  logic [LEN_BITS-1:0]         nml_mem [SLOT_COUNT];
  logic [LEN_BITS-1:0]         rcv_mem [SLOT_COUNT];

  logic                        vld_rd;
  logic [frt_pkg::ID_FW-1:0]   snd_rd;
  logic [LEN_BITS-1:0]         tot_rd;
  logic [LEN_BITS-1:0]         nml_rd;
  logic [LEN_BITS-1:0]         rcv_rd;

  logic                        dec_vld_we;
  logic                        dec_vld_wd;
  logic                        dec_ctx_we;
  logic [frt_pkg::ID_FW-1:0]   w_snd;
  logic [LEN_BITS-1:0]         w_tot;
  logic [LEN_BITS-1:0]         w_nml;
  logic [LEN_BITS-1:0]         w_rcv;

  logic                        vld_we;
  logic                        vld_wd;
  logic [SLOT_W-1:0]           vld_wa;

  assign vld_we = cmd.clear | (cmd.commit & dec_vld_we);
  assign vld_wd = cmd.clear ? 1'b0 : dec_vld_wd;
  assign vld_wa = cmd.clear ? clr_cnt : idx;

  always_ff @(posedge clk) begin
    if (vld_we) vld_mem[vld_wa] <= vld_wd;
    if (cmd.lookup) vld_rd <= vld_mem[idx_calc];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && dec_ctx_we) begin
      snd_mem[idx] <= w_snd;
      tot_mem[idx] <= w_tot;
      nml_mem[idx] <= w_nml;
      rcv_mem[idx] <= w_rcv;
    end
    if (cmd.lookup) begin
      snd_rd <= snd_mem[idx_calc];
      tot_rd <= tot_mem[idx_calc];
      nml_rd <= nml_mem[idx_calc];
      rcv_rd <= rcv_mem[idx_calc];
    end
  end

  // decision
  logic [LEN_BITS-1:0] tot;
  logic [LEN_BITS-1:0] nml;
  logic [LEN_BITS-1:0] part;
  logic [LEN_BITS:0]   sum;
  logic [LEN_BITS:0]   ctot_x;
  logic                part_big;
  logic                hit;
  logic                stale;
  frt_pkg::res_t       dec;

  assign tot      = LEN_BITS'(hdr_q.total_len);
  assign nml      = LEN_BITS'(hdr_q.name_part_len);
  assign part     = LEN_BITS'(hdr_q.part_len);
  assign sum      = {1'b0, rcv_rd} + {1'b0, part};
  assign ctot_x   = {1'b0, tot_rd};
  assign part_big = 32'(part) > 32'(MAX_PART_BODY);
  assign hit      = vld_rd && (snd_rd == hdr_q.src_id);
  assign stale    = vld_rd && !hit;

  always_comb begin
    dec               = '0;
    dec.action        = frt_pkg::ACT_FLUSH;
    dec.error_code    = frt_pkg::ERR_NONE;
    dec.out_slot      = hdr_q.sender_slot;
    dec.out_id        = hdr_q.src_id;
    dec_vld_we        = 1'b0;
    dec_vld_wd        = 1'b0;
    dec_ctx_we        = 1'b0;
    w_snd             = hdr_q.src_id;
    w_tot             = tot;
    w_nml             = nml;
    w_rcv             = part;
    if (part_big) begin
      dec.error_code = frt_pkg::ERR_PART_BIG;
    end else if (nml > tot) begin
      dec.error_code = frt_pkg::ERR_NAME_BIG;
    end else if (hdr_q.ctrl_code == frt_pkg::CTRL_UNKNOWN) begin
      dec.error_code = frt_pkg::ERR_UNKNOWN;
    end else if (hdr_q.ctrl_code == frt_pkg::CTRL_WHOLE) begin
      if (tot != part) begin
        dec.error_code = frt_pkg::ERR_WHOLE_MISMATCH;
      end else begin
        dec.action       = frt_pkg::ACT_WHOLE;
        dec.msg_name_len = frt_pkg::LEN_FW'(nml);
        dec.msg_data_len = frt_pkg::LEN_FW'(tot - nml);
      end
    end else if (tot <= part) begin
      dec.error_code = frt_pkg::ERR_TOTAL_SMALL;
    end else begin
      dec.stale_cleared = stale;
      dec.action        = frt_pkg::ACT_DROP;
      if (hit) begin
        dec_vld_we = 1'b1;
        dec_vld_wd = 1'b0;
        if (hdr_q.ctrl_code != frt_pkg::CTRL_CONT) begin
          dec.error_code = frt_pkg::ERR_EXP_CONT;
        end else if (tot != tot_rd) begin
          dec.error_code = frt_pkg::ERR_TOTAL_MISMATCH;
        end else if (sum > ctot_x) begin
          dec.error_code = frt_pkg::ERR_OVERRUN;
        end else if (sum == ctot_x) begin
          dec.action       = frt_pkg::ACT_COMPLETE;
          dec.write_offset = frt_pkg::LEN_FW'(rcv_rd);
          dec.msg_name_len = frt_pkg::LEN_FW'(nml_rd);
          dec.msg_data_len = frt_pkg::LEN_FW'(tot_rd - nml_rd);
        end else begin
          dec_vld_we       = 1'b0;
          dec_ctx_we       = 1'b1;
          w_snd            = snd_rd;
          w_tot            = tot_rd;
          w_nml            = nml_rd;
          w_rcv            = sum[LEN_BITS-1:0];
          dec.action       = frt_pkg::ACT_APPEND;
          dec.write_offset = frt_pkg::LEN_FW'(rcv_rd);
        end
      end else begin
        dec_vld_we = stale;
        dec_vld_wd = 1'b0;
        if (hdr_q.ctrl_code != frt_pkg::CTRL_FIRST) begin
          dec.error_code = frt_pkg::ERR_EXP_FIRST;
        end else begin
          dec_vld_we = 1'b1;
          dec_vld_wd = 1'b1;
          dec_ctx_we = 1'b1;
          dec.action = frt_pkg::ACT_START;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) res <= dec;
  end

  assign stat.res_free = !res_valid || !res_stall;

endmodule

FILE: rtl/fragment_reassembly_tracker.sv
// Fragment reassembly tracker: checks each packet header, keeps one reassembly
// context per sender slot and answers every header with exactly one request
// carrying the body action, error code, write offset and message lengths.
// A header goes through three steps: the accept cycle, a lookup cycle that reduces
// the slot to a context index and reads the context memory, and a decide cycle
// that updates the context and loads the result register. The decide cycle
// repeats while the result register still holds a request and res_stall is
// high. The result register lets the next header enter while a finished
// request still waits downstream.
// After reset a clearing pass resets the context valid bits, one slot a cycle,
// with hdr_stall held high. Slots at or above SLOT_COUNT share contexts with
// sender_slot modulo SLOT_COUNT.
// depends on frt_pkg, frt_ctrl, frt_datapath
`timescale 1ns / 1ps

module fragment_reassembly_tracker #(
  parameter int SLOT_COUNT    = 1024,
  parameter int MAX_PART_BODY = 4064,
  parameter int LEN_BITS      = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hdr_valid,
  output logic          hdr_stall,
  input  frt_pkg::hdr_t hdr,
  output logic          res_valid,
  input  logic          res_stall,
  output frt_pkg::res_t res
);

  frt_pkg::ctl_cmd_t cmd;
  frt_pkg::dp_stat_t stat;

  frt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  frt_datapath #(
    .SLOT_COUNT    (SLOT_COUNT),
    .MAX_PART_BODY (MAX_PART_BODY),
    .LEN_BITS      (LEN_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .hdr       (hdr),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

FILE: test/fragment_reassembly_tracker_tb.sv
// self-checking testbench for fragment_reassembly_tracker: directed headers, then
// random fragment streams and noise, with a scoreboard class that predicts each request
// depends on frt_pkg and fragment_reassembly_tracker
`timescale 1ns / 1ps

module fragment_reassembly_tracker_tb;
  import frt_pkg::*;

  localparam int SLOT_COUNT    = 1024;
  localparam int MAX_PART_BODY = 4064;
  localparam int LANES         = 6;
  localparam int POOL          = 24;
  localparam int RAND_ITEMS    = 900;

  class frag_tracker_sb;
    bit                ctx_valid    [SLOT_COUNT];
    logic [ID_FW-1:0]  ctx_sender   [SLOT_COUNT];
    logic [LEN_FW-1:0] ctx_total    [SLOT_COUNT];
    logic [LEN_FW-1:0] ctx_name     [SLOT_COUNT];
    logic [LEN_FW-1:0] ctx_received [SLOT_COUNT];
    res_t              pending_responses [$];
    int                mismatches;
    int                checked;

    function new();
      foreach (ctx_valid[i]) ctx_valid[i] = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function res_t predict_response(hdr_t h);
      res_t            r;
      int              ix;
      logic [LEN_FW:0] sum;
      r               = '0;
      r.action        = ACT_FLUSH;
      r.error_code    = ERR_NONE;
      r.out_slot      = h.sender_slot;
      r.out_id        = h.src_id;
      ix              = int'(h.sender_slot) % SLOT_COUNT;
      if (h.part_len > MAX_PART_BODY) begin
        r.error_code = ERR_PART_BIG;
      end else if (h.name_part_len > h.total_len) begin
        r.error_code = ERR_NAME_BIG;
      end else if (h.ctrl_code == CTRL_UNKNOWN) begin
        r.error_code = ERR_UNKNOWN;
      end else if (h.ctrl_code == CTRL_WHOLE) begin
        if (h.total_len != h.part_len) begin
          r.error_code = ERR_WHOLE_MISMATCH;
        end else begin
          r.action       = ACT_WHOLE;
          r.msg_name_len = h.name_part_len;
          r.msg_data_len = h.total_len - h.name_part_len;
        end
      end else if (h.total_len <= h.part_len) begin
        r.error_code = ERR_TOTAL_SMALL;
      end else begin
        r.action = ACT_DROP;
        // context owned by a different sender is thrown away first
        if (ctx_valid[ix] && ctx_sender[ix] != h.src_id) begin
          ctx_valid[ix]   = 1'b0;
          r.stale_cleared = 1'b1;
        end
        if (ctx_valid[ix]) begin
          sum = {1'b0, ctx_received[ix]} + h.part_len;
          if (h.ctrl_code != CTRL_CONT) begin
            ctx_valid[ix] = 1'b0;
            r.error_code  = ERR_EXP_CONT;
          end else if (h.total_len != ctx_total[ix]) begin
            ctx_valid[ix] = 1'b0;
            r.error_code  = ERR_TOTAL_MISMATCH;
          end else if (sum > ctx_total[ix]) begin
            ctx_valid[ix] = 1'b0;
            r.error_code  = ERR_OVERRUN;
          end else if (sum == ctx_total[ix]) begin
            ctx_valid[ix]  = 1'b0;
            r.action       = ACT_COMPLETE;
            r.write_offset = ctx_received[ix];
            r.msg_name_len = ctx_name[ix];
            r.msg_data_len = ctx_total[ix] - ctx_name[ix];
          end else begin
            r.action          = ACT_APPEND;
            r.write_offset    = ctx_received[ix];
            ctx_received[ix]  = sum[LEN_FW-1:0];
          end
        end else if (h.ctrl_code != CTRL_FIRST) begin
          r.error_code = ERR_EXP_FIRST;
        end else begin
          r.action          = ACT_START;
          ctx_valid[ix]     = 1'b1;
          ctx_sender[ix]    = h.src_id;
          ctx_total[ix]     = h.total_len;
          ctx_name[ix]      = h.name_part_len;
          ctx_received[ix]  = h.part_len;
        end
      end
      return r;
    endfunction

    function void note_header(hdr_t h);
      pending_responses.push_back(predict_response(h));
    endfunction

    task report(string msg);
      if (mismatches < 60) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("request %0d %s got 0x%0h want 0x%0h", checked, field, got, want));
    endtask

    task check_response(res_t r);
      res_t want;
      if (pending_responses.size() == 0) begin
        report($sformatf("request with no header outstanding: 0x%0h", r));
        return;
      end
      want = pending_responses.pop_front();
      check_field("action", r.action, want.action);
      check_field("error_code", r.error_code, want.error_code);
      check_field("write_offset", r.write_offset, want.write_offset);
      check_field("msg_name_len", r.msg_name_len, want.msg_name_len);
      check_field("msg_data_len", r.msg_data_len, want.msg_data_len);
      check_field("stale_cleared", r.stale_cleared, want.stale_cleared);
      check_field("out_slot", r.out_slot, want.out_slot);
      check_field("out_id", r.out_id, want.out_id);
      checked++;
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic hdr_valid = 1'b0;
  logic res_stall = 1'b0;
  logic calm      = 1'b0;
  hdr_t hdr       = '0;
  logic hdr_stall;
  logic res_valid;
  res_t res;

  frag_tracker_sb book;

  fragment_reassembly_tracker #(
    .SLOT_COUNT   (SLOT_COUNT),
    .MAX_PART_BODY(MAX_PART_BODY),
    .LEN_BITS     (16)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .hdr_valid(hdr_valid),
    .hdr_stall(hdr_stall),
    .hdr      (hdr),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #10 clk = ~clk;

  function automatic hdr_t mk_hdr(ctrl_code_t c, int slot, int id, int tot, int name,
                                  int part);
    hdr_t h;
    h.ctrl_code     = c;
    h.sender_slot   = slot[SLOT_FW-1:0];
    h.src_id        = id[ID_FW-1:0];
    h.total_len     = tot[LEN_FW-1:0];
    h.name_part_len = name[LEN_FW-1:0];
    h.part_len      = part[LEN_FW-1:0];
    return h;
  endfunction

  task automatic send_header(input hdr_t h);
    while (!calm && $urandom_range(0, 99) < 29) begin
      hdr_valid <= 1'b0;
      @(posedge clk);
    end
    hdr_valid <= 1'b1;
    hdr       <= h;
    @(posedge clk);
    while (hdr_stall) @(posedge clk);
    book.note_header(h);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) book.check_response(res);
    res_stall <= !calm && ($urandom_range(0, 99) < 29);
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int   slot_pool [POOL];
    bit   lane_busy [LANES];
    bit   lane_seen [LANES];
    int   lane_slot [LANES];
    int   lane_id   [LANES];
    int   lane_tot  [LANES];
    int   lane_name [LANES];
    int   lane_sent [LANES];
    int   n;
    int   roll;
    int   lane;
    int   rem;
    int   part;
    int   tot;
    hdr_t h;

    book = new();
    slot_pool[0] = 0;
    slot_pool[1] = SLOT_COUNT - 1;
    for (int i = 2; i < POOL; i++) slot_pool[i] = $urandom_range(0, SLOT_COUNT - 1);
    foreach (lane_busy[i]) begin
      lane_busy[i] = 1'b0;
      lane_seen[i] = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed headers: field extremes and every error path
    send_header(mk_hdr(CTRL_WHOLE, 0, 0, 0, 0, 0));
    send_header(mk_hdr(CTRL_WHOLE, 1023, 'h3FFFFF, 4064, 4064, 4064));
    send_header(mk_hdr(CTRL_FIRST, 3, 9, 65535, 65535, 4065));
    send_header(mk_hdr(CTRL_UNKNOWN, 1023, 'h3FFFFF, 65535, 65535, 65535));
    send_header(mk_hdr(CTRL_FIRST, 4, 9, 10, 11, 5));
    send_header(mk_hdr(CTRL_UNKNOWN, 4, 9, 10, 2, 3));
    send_header(mk_hdr(CTRL_WHOLE, 4, 9, 100, 10, 99));
    send_header(mk_hdr(CTRL_FIRST, 4, 9, 50, 10, 50));
    send_header(mk_hdr(CTRL_CONT, 5, 7, 100, 20, 10));
    send_header(mk_hdr(CTRL_FIRST, 5, 7, 100, 20, 40));
    send_header(mk_hdr(CTRL_CONT, 5, 7, 100, 0, 30));
    send_header(mk_hdr(CTRL_CONT, 5, 7, 100, 0, 30));
    send_header(mk_hdr(CTRL_FIRST, 1023, 'h3FFFFF, 65535, 65535, 4064));
    send_header(mk_hdr(CTRL_CONT, 1023, 'h3FFFFF, 65534, 0, 10));
    send_header(mk_hdr(CTRL_CONT, 1023, 'h3FFFFF, 65534, 0, 10));
    send_header(mk_hdr(CTRL_FIRST, 6, 1, 200, 0, 100));
    send_header(mk_hdr(CTRL_FIRST, 6, 1, 200, 0, 100));
    send_header(mk_hdr(CTRL_FIRST, 6, 1, 200, 0, 100));
    send_header(mk_hdr(CTRL_CONT, 6, 1, 200, 0, 101));
    send_header(mk_hdr(CTRL_FIRST, 7, 2, 300, 5, 10));
    send_header(mk_hdr(CTRL_FIRST, 7, 3, 300, 5, 10));
    send_header(mk_hdr(CTRL_CONT, 7, 2, 300, 5, 10));
    send_header(mk_hdr(CTRL_FIRST, 8, 4, 10, 3, 0));
    send_header(mk_hdr(CTRL_CONT, 8, 4, 10, 3, 10));

    // random: fragment streams on a few lanes, whole packets and raw noise
    for (n = 0; n < RAND_ITEMS; n++) begin
      calm <= (n >= 400 && n < 560);
      roll = $urandom_range(0, 99);
      lane = $urandom_range(0, LANES - 1);
      if (roll < 15) begin
        h.ctrl_code     = ctrl_code_t'($urandom_range(0, 3));
        h.sender_slot   = SLOT_FW'($urandom);
        h.src_id        = ID_FW'($urandom);
        h.total_len     = LEN_FW'($urandom);
        h.name_part_len = LEN_FW'($urandom);
        h.part_len      = LEN_FW'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          h.total_len     = LEN_FW'($urandom_range(0, 300));
          h.name_part_len = LEN_FW'($urandom_range(0, 300));
          h.part_len      = LEN_FW'($urandom_range(0, 300));
        end
      end else if (roll < 25) begin
        tot  = $urandom_range(0, MAX_PART_BODY);
        part = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PART_BODY) : tot;
        h = mk_hdr(CTRL_WHOLE, slot_pool[$urandom_range(0, POOL - 1)], $urandom, tot,
                   $urandom_range(0, tot), part);
      end else if (!lane_busy[lane]) begin
        lane_slot[lane] = slot_pool[$urandom_range(0, POOL - 1)];
        if (!lane_seen[lane] || $urandom_range(0, 9) < 2) lane_id[lane] = $urandom;
        lane_seen[lane] = 1'b1;
        lane_tot[lane]  = ($urandom_range(0, 19) == 0) ? $urandom_range(4065, 65535)
                                                       : $urandom_range(1, 300);
        lane_name[lane] = $urandom_range(0, lane_tot[lane]);
        part = $urandom_range(0, (lane_tot[lane] - 1 < MAX_PART_BODY) ? lane_tot[lane] - 1
                                                                      : MAX_PART_BODY);
        lane_sent[lane] = part;
        lane_busy[lane] = 1'b1;
        h = mk_hdr(CTRL_FIRST, lane_slot[lane], lane_id[lane], lane_tot[lane],
                   lane_name[lane], part);
      end else begin
        rem  = lane_tot[lane] - lane_sent[lane];
        roll = $urandom_range(0, 99);
        tot  = lane_tot[lane];
        if (roll < 4) begin
          lane_busy[lane] = 1'b0;
          h = mk_hdr(CTRL_FIRST, lane_slot[lane], lane_id[lane], tot, lane_name[lane],
                     $urandom_range(0, (tot - 1 < MAX_PART_BODY) ? tot - 1 : MAX_PART_BODY));
        end else if (roll < 8) begin
          lane_busy[lane] = 1'b0;
          h = mk_hdr(CTRL_CONT, lane_slot[lane], lane_id[lane],
                     tot ^ $urandom_range(1, 65535), 0, $urandom_range(0, 20));
        end else if (roll < 12) begin
          lane_busy[lane] = 1'b0;
          h = mk_hdr(CTRL_CONT, lane_slot[lane], lane_id[lane], tot, 0,
                     rem + $urandom_range(1, 10));
        end else begin
          if (rem <= MAX_PART_BODY && $urandom_range(0, 2) == 0)
            part = rem;
          else
            part = $urandom_range(0, (rem < MAX_PART_BODY) ? rem : MAX_PART_BODY);
          lane_sent[lane] += part;
          if (lane_sent[lane] == tot) lane_busy[lane] = 1'b0;
          h = mk_hdr(CTRL_CONT, lane_slot[lane], lane_id[lane], tot, 0, part);
        end
      end
      send_header(h);
    end
    hdr_valid <= 1'b0;

    while (book.pending_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.mismatches == 0 && book.pending_responses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/frt_pkg.sv
rtl/frt_ctrl.sv
rtl/frt_datapath.sv
rtl/fragment_reassembly_tracker.sv
test/fragment_reassembly_tracker_tb.sv
